// ----- src/face_box_smoother_roi_assert.svh -----
// Assertion macros for the face box smoother checker.
`ifndef FACE_BOX_SMOOTHER_ROI_ASSERT_SVH
`define FACE_BOX_SMOOTHER_ROI_ASSERT_SVH

// Check a property only while out of reset.
`define FBS_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FBS_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/fbs_pkg.sv -----
// Shared types, constants and helper functions of the face box smoother.
`default_nettype none

package fbs_pkg;

    localparam int DET_W      = 10;
    localparam int HIST_W     = 14;
    localparam int OUT_W      = 13;
    localparam int SCALE_W    = 5;
    localparam int FRAME_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int WINDOW_DEF = 7;

    localparam logic [HIST_W-1:0]  HIST_MAX = 14'd16383;
    localparam logic [OUT_W-1:0]   OUT_MAX  = 13'd8191;

    localparam logic [SCALE_W-1:0] SCALE_RST = 5'd7;
    localparam logic [FRAME_W-1:0] WIDTH_RST = 13'd1920;
    localparam logic [FRAME_W-1:0] HEIGHT_RST = 13'd1080;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_UP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // Coordinate slots of a box
    localparam logic [1:0] C_LEFT   = 2'd0;
    localparam logic [1:0] C_TOP    = 2'd1;
    localparam logic [1:0] C_RIGHT  = 2'd2;
    localparam logic [1:0] C_BOTTOM = 2'd3;

    typedef logic [3:0][DET_W-1:0]  t_det_box;
    typedef logic [3:0][HIST_W-1:0] t_box;

    // floor(n / 5) by reciprocal, exact for any 15-bit n
    function automatic logic [HIST_W-1:0] div5(input logic [HIST_W:0] n);
        logic [31:0] prod;
        prod = 32'(n) * 32'd52429;
        return prod[18 +: HIST_W];
    endfunction

    // Clamp a scaled coordinate to the output range.
    function automatic logic [OUT_W-1:0] sat_out(input logic [HIST_W-1:0] v);
        return v[HIST_W-1] ? OUT_MAX : v[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/fbs_det_if.sv -----
// Detection input channel: valid/ready handshake with one face box.
`default_nettype none

interface fbs_det_if;
    logic       valid;
    logic       ready;
    logic       face_found;
    logic [9:0] det_left;
    logic [9:0] det_top;
    logic [9:0] det_right;
    logic [9:0] det_bottom;

    modport source (output valid, face_found, det_left, det_top, det_right, det_bottom,
                    input ready);
    modport sink   (input valid, face_found, det_left, det_top, det_right, det_bottom,
                    output ready);
endinterface

`default_nettype wire

// ----- src/fbs_roi_if.sv -----
// Region output channel: valid/ready handshake with one region of interest.
`default_nettype none

interface fbs_roi_if;
    logic        valid;
    logic        ready;
    logic        roi_valid;
    logic [12:0] roi_left;
    logic [12:0] roi_top;
    logic [12:0] roi_right;
    logic [12:0] roi_bottom;

    modport source (output valid, roi_valid, roi_left, roi_top, roi_right, roi_bottom,
                    input ready);
    modport sink   (input valid, roi_valid, roi_left, roi_top, roi_right, roi_bottom,
                    output ready);
endinterface

`default_nettype wire

// ----- src/fbs_hist.sv -----
// Box history: shift line of the last WINDOW boxes with running coordinate sums.
`default_nettype none

module fbs_hist #(
    parameter int WINDOW = fbs_pkg::WINDOW_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  fbs_pkg::t_box    i_box,
    output logic             o_full,
    output logic [3:0][fbs_pkg::HIST_W+$clog2(WINDOW)-1:0] o_sum
);

    localparam int SUMW = fbs_pkg::HIST_W + $clog2(WINDOW);
    localparam int CNTW = $clog2(WINDOW + 1);

    fbs_pkg::t_box                r_hist [WINDOW];
    logic [CNTW-1:0]              r_cnt;
    logic [3:0][SUMW-1:0]         r_sum;
    logic [3:0][SUMW-1:0]         n_sum;

    assign o_full = (r_cnt == CNTW'(WINDOW));
    assign o_sum  = r_sum;

    // add the new box, drop the oldest once the window is full
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_sum[c] = r_sum[c] + SUMW'(i_box[c])
                     - (o_full ? SUMW'(r_hist[0][c]) : SUMW'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
        end else if (i_push) begin
            r_sum <= n_sum;
            if (!o_full) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
        end
    end

    // oldest entry at slot 0 once the window is full
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                r_hist[i] <= r_hist[i + 1];
            end
            r_hist[WINDOW - 1] <= i_box;
        end
    end

endmodule

`default_nettype wire

// ----- src/face_box_smoother_roi.sv -----
// Top level of the face box smoother with region-of-interest shrink.
`default_nettype none

// Takes one detected face box per transfer on i_det, scales it to frame
// pixels by scale_up and smooths it over the last WINDOW boxes: until WINDOW
// boxes have been seen the current box is used, afterwards the floored mean
// of the stored boxes (taken before the current box enters). The chosen box
// is shrunk to a region of interest and sent on o_roi; a transfer without a
// face, or one whose box or region is empty, yields roi_valid = 0 and zero
// coordinates. Throughput is one transfer per clock while o_roi is ready; each
// result passes in order through the registers of the pipeline (input
// register, scale multiply, history update, reciprocal multiply, remainder
// correction, corner ordering, divide-by-five multiplies, edge revert, output
// register). Each stage holds independently, so bubbles close up while the
// output waits. Write the configuration registers only while no transfer is
// in flight.
module face_box_smoother_roi #(
    parameter int WINDOW = fbs_pkg::WINDOW_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    fbs_det_if.sink                              i_det,
    fbs_roi_if.source                            o_roi
);

    localparam int HW   = fbs_pkg::HIST_W;
    localparam int OW   = fbs_pkg::OUT_W;
    localparam int SUMW = HW + $clog2(WINDOW);
    localparam int PRDW = 2 * SUMW + 1;
    localparam int NST  = 8;

    // floor(2^SUMW / WINDOW): the quotient estimate is low by at most one
    localparam logic [SUMW:0]   RECIP = (SUMW + 1)'((64'd1 << SUMW) / WINDOW);
    localparam logic [SUMW-1:0] WIN_C = SUMW'(WINDOW);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [fbs_pkg::SCALE_W-1:0] r_scale;
    logic [fbs_pkg::FRAME_W-1:0] r_fw;
    logic [fbs_pkg::FRAME_W-1:0] r_fh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= fbs_pkg::SCALE_RST;
            r_fw    <= fbs_pkg::WIDTH_RST;
            r_fh    <= fbs_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fbs_pkg::REG_SCALE_UP:     r_scale <= i_cfg_data[fbs_pkg::SCALE_W-1:0];
                fbs_pkg::REG_FRAME_WIDTH:  r_fw    <= i_cfg_data;
                fbs_pkg::REG_FRAME_HEIGHT: r_fh    <= i_cfg_data;
                default: ;  // no register there, drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline flow control: stage k loads whenever it is empty or moves on
    // ---------------------------------------------------------------------
    logic [NST:1]   r_vld;
    logic [NST+1:1] w_rdy;
    logic           r_ov;

    always_comb begin
        w_rdy[NST+1] = !r_ov || o_roi.ready;
        for (int k = NST; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign i_det.ready = w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= i_det.valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_rdy[NST+1]) begin
                r_ov <= r_vld[NST];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: capture the detection
    // ---------------------------------------------------------------------
    logic              r_p1_face;
    fbs_pkg::t_det_box r_p1_det;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_p1_face                <= i_det.face_found;
            r_p1_det[fbs_pkg::C_LEFT]   <= i_det.det_left;
            r_p1_det[fbs_pkg::C_TOP]    <= i_det.det_top;
            r_p1_det[fbs_pkg::C_RIGHT]  <= i_det.det_right;
            r_p1_det[fbs_pkg::C_BOTTOM] <= i_det.det_bottom;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: scale to frame pixels, saturate at the history range
    // ---------------------------------------------------------------------
    logic          r_p2_face;
    fbs_pkg::t_box r_p2_box;
    fbs_pkg::t_box w_scaled;
    logic [3:0][HW:0] w_prod;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_prod[c]   = (HW + 1)'(r_p1_det[c]) * (HW + 1)'(r_scale);
            w_scaled[c] = w_prod[c][HW] ? fbs_pkg::HIST_MAX : w_prod[c][HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_p2_face <= r_p1_face;
            r_p2_box  <= w_scaled;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: snapshot the history sums, then push the current box
    // ---------------------------------------------------------------------
    logic                 w_push;
    logic                 w_full;
    logic [3:0][SUMW-1:0] w_sum;

    // only a face moves the history
    assign w_push = r_vld[2] && w_rdy[3] && r_p2_face;

    fbs_hist #(
        .WINDOW (WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_box   (r_p2_box),
        .o_full  (w_full),
        .o_sum   (w_sum)
    );

    logic                 r_p3_face;
    logic                 r_p3_full;
    logic [3:0][SUMW-1:0] r_p3_sum;
    fbs_pkg::t_box        r_p3_box;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_p3_face <= r_p2_face;
            r_p3_full <= w_full;
            r_p3_sum  <= w_sum;
            r_p3_box  <= r_p2_box;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: quotient estimate of sum / WINDOW by reciprocal multiply
    // ---------------------------------------------------------------------
    logic [3:0][PRDW-1:0] w_qprod;
    logic                 r_p4_face;
    logic                 r_p4_full;
    logic [3:0][HW-1:0]   r_p4_qe;
    logic [3:0][SUMW-1:0] r_p4_sum;
    fbs_pkg::t_box        r_p4_box;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_qprod[c] = PRDW'(r_p3_sum[c]) * PRDW'(RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_p4_face <= r_p3_face;
            r_p4_full <= r_p3_full;
            r_p4_sum  <= r_p3_sum;
            r_p4_box  <= r_p3_box;
            for (int c = 0; c < 4; c++) begin
                r_p4_qe[c] <= w_qprod[c][SUMW +: HW];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: correct the estimate, choose mean or current box
    // ---------------------------------------------------------------------
    logic [3:0][SUMW-1:0] w_rem;
    fbs_pkg::t_box        w_choice;
    logic                 r_p5_face;
    fbs_pkg::t_box        r_p5_box;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_rem[c]    = r_p4_sum[c] - SUMW'(SUMW'(r_p4_qe[c]) * WIN_C);
            w_choice[c] = r_p4_full
                        ? r_p4_qe[c] + HW'(w_rem[c] >= WIN_C)
                        : r_p4_box[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_p5_face <= r_p4_face;
            r_p5_box  <= w_choice;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 6: order the corners, take width and height
    // ---------------------------------------------------------------------
    logic [HW-1:0] w_x0, w_x1, w_y0, w_y1;
    logic          r_p6_ok;
    logic [HW-1:0] r_p6_x0, r_p6_x1, r_p6_y0, r_p6_y1, r_p6_w, r_p6_h;

    always_comb begin
        if (r_p5_box[fbs_pkg::C_LEFT] > r_p5_box[fbs_pkg::C_RIGHT]) begin
            w_x0 = r_p5_box[fbs_pkg::C_RIGHT];
            w_x1 = r_p5_box[fbs_pkg::C_LEFT];
        end else begin
            w_x0 = r_p5_box[fbs_pkg::C_LEFT];
            w_x1 = r_p5_box[fbs_pkg::C_RIGHT];
        end
        if (r_p5_box[fbs_pkg::C_TOP] > r_p5_box[fbs_pkg::C_BOTTOM]) begin
            w_y0 = r_p5_box[fbs_pkg::C_BOTTOM];
            w_y1 = r_p5_box[fbs_pkg::C_TOP];
        end else begin
            w_y0 = r_p5_box[fbs_pkg::C_TOP];
            w_y1 = r_p5_box[fbs_pkg::C_BOTTOM];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            // an empty box gives no region
            r_p6_ok <= r_p5_face && (w_x0 != w_x1) && (w_y0 != w_y1);
            r_p6_x0 <= w_x0;
            r_p6_x1 <= w_x1;
            r_p6_y0 <= w_y0;
            r_p6_y1 <= w_y1;
            r_p6_w  <= w_x1 - w_x0;
            r_p6_h  <= w_y1 - w_y0;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 7: shrink amounts w/5, ceil(w/5), h/2, ceil(h/10)
    // ---------------------------------------------------------------------
    logic [HW:0]   w_h9;
    logic          r_p7_ok;
    logic [HW-1:0] r_p7_x0, r_p7_x1, r_p7_y0, r_p7_y1;
    logic [HW-1:0] r_p7_dl, r_p7_dr, r_p7_dt, r_p7_db;

    // ceil(h/10) = floor(floor((h + 9) / 2) / 5)
    assign w_h9 = (HW + 1)'(r_p6_h) + (HW + 1)'(9);

    always_ff @(posedge i_clk) begin
        if (w_rdy[7]) begin
            r_p7_ok <= r_p6_ok;
            r_p7_x0 <= r_p6_x0;
            r_p7_x1 <= r_p6_x1;
            r_p7_y0 <= r_p6_y0;
            r_p7_y1 <= r_p6_y1;
            r_p7_dl <= fbs_pkg::div5({1'b0, r_p6_w});
            r_p7_dr <= fbs_pkg::div5((HW + 1)'(r_p6_w) + (HW + 1)'(4));
            r_p7_dt <= r_p6_h >> 1;
            r_p7_db <= fbs_pkg::div5({1'b0, w_h9[HW:1]});
        end
    end

    // ---------------------------------------------------------------------
    // Stage 8: move the edges, revert left or top at zero and right or bottom outside the frame
    // ---------------------------------------------------------------------
    logic [HW-1:0] w_nl, w_nt, w_nr, w_nb;
    logic          r_p8_ok;
    logic [HW-1:0] r_p8_nl, r_p8_nt, r_p8_nr, r_p8_nb;

    always_comb begin
        w_nl = r_p7_x0 + r_p7_dl;
        if (w_nl == '0) begin
            w_nl = r_p7_x0;
        end
        w_nt = r_p7_y0 + r_p7_dt;
        if (w_nt == '0) begin
            w_nt = r_p7_y0;
        end
        w_nr = r_p7_x1 - r_p7_dr;
        if (w_nr >= HW'(r_fw)) begin
            w_nr = r_p7_x1;
        end
        w_nb = r_p7_y1 - r_p7_db;
        if (w_nb >= HW'(r_fh)) begin
            w_nb = r_p7_y1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[8]) begin
            r_p8_ok <= r_p7_ok;
            r_p8_nl <= w_nl;
            r_p8_nt <= w_nt;
            r_p8_nr <= w_nr;
            r_p8_nb <= w_nb;
        end
    end

    // ---------------------------------------------------------------------
    // Output register: order, saturate, blank an empty region
    // ---------------------------------------------------------------------
    logic [OW-1:0] w_a0, w_a1, w_c0, w_c1;
    logic          w_keep;
    logic          r_ok;
    logic [OW-1:0] r_left, r_top, r_right, r_bottom;

    always_comb begin
        w_a0   = fbs_pkg::sat_out((r_p8_nl < r_p8_nr) ? r_p8_nl : r_p8_nr);
        w_a1   = fbs_pkg::sat_out((r_p8_nl < r_p8_nr) ? r_p8_nr : r_p8_nl);
        w_c0   = fbs_pkg::sat_out((r_p8_nt < r_p8_nb) ? r_p8_nt : r_p8_nb);
        w_c1   = fbs_pkg::sat_out((r_p8_nt < r_p8_nb) ? r_p8_nb : r_p8_nt);
        w_keep = r_p8_ok && (w_a0 != w_a1) && (w_c0 != w_c1);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NST+1]) begin
            r_ok     <= w_keep;
            r_left   <= w_keep ? w_a0 : '0;
            r_top    <= w_keep ? w_c0 : '0;
            r_right  <= w_keep ? w_a1 : '0;
            r_bottom <= w_keep ? w_c1 : '0;
        end
    end

    assign o_roi.valid      = r_ov;
    assign o_roi.roi_valid  = r_ok;
    assign o_roi.roi_left   = r_left;
    assign o_roi.roi_top    = r_top;
    assign o_roi.roi_right  = r_right;
    assign o_roi.roi_bottom = r_bottom;

endmodule

`default_nettype wire

// ----- src/fbs_checker.sv -----
// Port-level checker for the face box smoother, bound to the top level.
`default_nettype none

`include "face_box_smoother_roi_assert.svh"

module fbs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_roi_valid,
    input wire logic [12:0] i_roi_left,
    input wire logic [12:0] i_roi_top,
    input wire logic [12:0] i_roi_right,
    input wire logic [12:0] i_roi_bottom
);

    // no region means all coordinates zero
    `FBS_ASSERT_RUN(a_blank_zero, i_clk, i_rst_n, (i_out_valid && !i_roi_valid) |-> (i_roi_left == 13'd0 && i_roi_top == 13'd0 && i_roi_right == 13'd0 && i_roi_bottom == 13'd0), "invalid region carries nonzero coordinates")

    // a given region is never empty or inverted
    `FBS_ASSERT_RUN(a_region_order, i_clk, i_rst_n, (i_out_valid && i_roi_valid) |-> (i_roi_left < i_roi_right && i_roi_top < i_roi_bottom), "region empty or inverted")

    // hold a stalled result
    `FBS_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_roi_valid) && $stable(i_roi_left) && $stable(i_roi_right) && $stable(i_roi_top) && $stable(i_roi_bottom)), "stalled result changed")

    // reset leaves no result pending
    `FBS_ASSERT_ALL(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result present after reset")

endmodule

bind face_box_smoother_roi fbs_checker u_fbs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_roi.valid),
    .i_out_ready  (o_roi.ready),
    .i_roi_valid  (o_roi.roi_valid),
    .i_roi_left   (o_roi.roi_left),
    .i_roi_top    (o_roi.roi_top),
    .i_roi_right  (o_roi.roi_right),
    .i_roi_bottom (o_roi.roi_bottom)
);

`default_nettype wire
